// ===== sv/dbs_pkg.sv =====
// Shared types and constants for the door bus slave command bridge.
`default_nettype none
package dbs_pkg;

   // Input item kinds carried in tuser
   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_READ  = 2'd1,
      OP_WRITE = 2'd2,
      OP_USER  = 2'd3
   } op_type;

   // Configuration register indexes
   localparam logic REG_PRESS_TIME   = 1'b0;
   localparam logic REG_LINK_TIMEOUT = 1'b1;

   localparam int unsigned DEFAULT_MAX_READ_WORDS = 64;
   localparam int unsigned CNT_W = 7;

   // Bus register addresses
   localparam logic [15:0] ADDR_CMD   = 16'h9C41;
   localparam logic [15:0] ADDR_STATE = 16'h9CB9;
   localparam logic [15:0] ADDR_BCAST = 16'h9D31;

   // Pending command codes
   localparam logic [1:0] CMD_NONE    = 2'd0;
   localparam logic [1:0] CMD_OPEN    = 2'd1;
   localparam logic [1:0] CMD_CLOSE   = 2'd2;
   localparam logic [1:0] CMD_IMPULSE = 2'd3;

   // Key press and release words
   localparam logic [15:0] PRESS_OPEN      = 16'h0210;
   localparam logic [15:0] RELEASE_OPEN    = 16'h0110;
   localparam logic [15:0] PRESS_CLOSE     = 16'h0220;
   localparam logic [15:0] RELEASE_CLOSE   = 16'h0120;
   localparam logic [15:0] PRESS_IMPULSE   = 16'h0240;
   localparam logic [15:0] RELEASE_IMPULSE = 16'h0140;

   // Fixed words of the five-word status reply
   localparam logic [15:0] INFO_WORD2 = 16'h0430;
   localparam logic [15:0] INFO_WORD3 = 16'h10FF;
   localparam logic [15:0] INFO_WORD4 = 16'hA845;

   // Door states reported to the user
   localparam logic [3:0] ST_STOPPED  = 4'd0;
   localparam logic [3:0] ST_OPENING  = 4'd1;
   localparam logic [3:0] ST_CLOSING  = 4'd2;
   localparam logic [3:0] ST_OPEN     = 4'd3;
   localparam logic [3:0] ST_CLOSED   = 4'd4;
   localparam logic [3:0] ST_HALF     = 4'd5;
   localparam logic [3:0] ST_MOVEVENT = 4'd6;
   localparam logic [3:0] ST_MOVEHALF = 4'd7;
   localparam logic [3:0] ST_VENT     = 4'd8;
   localparam logic [3:0] ST_UNKNOWN  = 4'd9;

   // State codes in the high byte of the broadcast state word
   localparam logic [7:0] BC_STOPPED  = 8'h00;
   localparam logic [7:0] BC_OPENING  = 8'h01;
   localparam logic [7:0] BC_CLOSING  = 8'h02;
   localparam logic [7:0] BC_MOVEHALF = 8'h05;
   localparam logic [7:0] BC_MOVEVENT = 8'h09;
   localparam logic [7:0] BC_VENT     = 8'h0A;
   localparam logic [7:0] BC_OPEN     = 8'h20;
   localparam logic [7:0] BC_CLOSED   = 8'h40;
   localparam logic [7:0] BC_HALF     = 8'h80;
   localparam logic [7:0] BC_VENT_SUB = 8'h61;

   // User request kinds
   localparam logic [2:0] RQ_OPEN    = 3'd0;
   localparam logic [2:0] RQ_CLOSE   = 3'd1;
   localparam logic [2:0] RQ_IMPULSE = 3'd2;
   localparam logic [2:0] RQ_STOP    = 3'd3;
   localparam logic [2:0] RQ_GOTO    = 3'd4;

   localparam logic [16:0] IDLE_MAX  = 17'h1FFFF;
   localparam logic [10:0] PRESS_MAX = 11'h7FF;

   typedef struct packed {
      op_type      opcode;
      logic [15:0] reg_address;
      logic [6:0]  word_count;
      logic [15:0] data_word0;
      logic [15:0] data_word1;
      logic [15:0] data_word2;
      logic [2:0]  request_kind;
      logic [6:0]  target_percent;
   } req_item_type;

   // One input's worth of results, played out word by word
   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic             data_flag;
      logic [4:0][15:0] words;
      logic [3:0]       door_state;
      logic [7:0]       door_position;
      logic             connected;
      logic             refused;
   } desc_type;

endpackage
`default_nettype wire

// ===== sv/door_bus_slave_command_bridge.sv =====
// Top level of the door bus slave command bridge: input register, core, reply player.
//
//  channel | role   | ports                          | payload
//  req     | slave  | req_tvalid/tready/tdata/tuser  | bus event, opcode in tuser
//  rsp     | master | rsp_tvalid/tready/tdata/tuser  | reply word and status, tlast ends reply
//  csr     | write  | csr_we/csr_index/csr_wdata     | press time, link timeout
//
// An item waits in the input register while the core decodes it, then loads into the
// reply register once that is free, which offers its first result; n result words
// follow, one per cycle while rsp_tready holds (n is 1 except for reads). Throughput
// is one item per cycle while replies are single words and rsp does not stall; a read
// of n words holds the reply register until its last word is taken. Reset is synchronous
// and needs no clearing pass. rsp stalls back up through the input register to req_tready.
`default_nettype none
module door_bus_slave_command_bridge
   import dbs_pkg::*;
#(
   parameter int unsigned MAX_READ_WORDS = DEFAULT_MAX_READ_WORDS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // reg_address, word_count, data_word0, data_word1, data_word2, request_kind,
   // target_percent, zero pad
   input  wire logic [87:0] req_tdata,
   // opcode
   input  wire logic [1:0]  req_tuser,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // reply_word, door_state, door_position, connected, request_refused, zero pad
   output      logic [31:0] rsp_tdata,
   // word_valid
   output      logic        rsp_tuser,
   output      logic        rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata
);

   req_item_type item_ff;
   logic         item_valid_ff;
   logic         advance;
   logic         emit_free;
   desc_type     desc;
   logic [15:0]  word;
   logic [3:0]   state;
   logic [7:0]   position;
   logic         connected;
   logic         refused;

   assign advance    = item_valid_ff && emit_free;
   assign req_tready = !item_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) item_valid_ff <= 1'b0;
      else if (req_tready) item_valid_ff <= req_tvalid;
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff.opcode         <= op_type'(req_tuser);
         item_ff.reg_address    <= req_tdata[15:0];
         item_ff.word_count     <= req_tdata[22:16];
         item_ff.data_word0     <= req_tdata[38:23];
         item_ff.data_word1     <= req_tdata[54:39];
         item_ff.data_word2     <= req_tdata[70:55];
         item_ff.request_kind   <= req_tdata[73:71];
         item_ff.target_percent <= req_tdata[80:74];
      end
   end

   dbs_core #(.MAX_READ_WORDS(MAX_READ_WORDS)) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .item      (item_ff),
      .advance   (advance),
      .desc      (desc)
   );

   dbs_emit #(.MAX_READ_WORDS(MAX_READ_WORDS)) u_emit (
      .clock         (clock),
      .reset         (reset),
      .desc          (desc),
      .load          (advance),
      .free          (emit_free),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_word      (word),
      .out_flag      (rsp_tuser),
      .out_last      (rsp_tlast),
      .out_state     (state),
      .out_position  (position),
      .out_connected (connected),
      .out_refused   (refused)
   );

   assign rsp_tdata = {2'b00, refused, connected, position, state, word};

`ifndef SYNTHESIS
   // status results are always single
   a_status_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast)
      else $error("status result without tlast");

   // a reply in progress is never cut short
   a_reply_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("reply dropped before its last word");

   // refusals only come on status results
   a_refused_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[29] |-> !rsp_tuser)
      else $error("refused flag on read data");
`endif

endmodule
`default_nettype wire

// ===== sv/dbs_core.sv =====
// Bridge state, configuration registers and per-transaction decode.
`default_nettype none
module dbs_core
   import dbs_pkg::*;
#(
   parameter int unsigned MAX_READ_WORDS = DEFAULT_MAX_READ_WORDS
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_we,
   input  wire logic         csr_index,
   input  wire logic [15:0]  csr_wdata,
   input  wire req_item_type item,
   input  wire logic         advance,
   output      desc_type     desc
);

   logic [9:0]  press_time_ff;
   logic [15:0] link_timeout_ff;

   logic [15:0] command_word_ff, command_word_in;
   logic [1:0]  pending_ff, pending_in;
   logic        key_pressed_ff, key_pressed_in;
   logic [10:0] press_timer_ff, press_timer_in;
   logic [16:0] idle_timer_ff, idle_timer_in;
   logic        link_up_ff, link_up_in;
   logic [15:0] last_pos_ff, last_pos_in;
   logic [15:0] last_state_ff, last_state_in;
   logic [3:0]  door_mode_ff, door_mode_in;
   logic [7:0]  position_ff, position_in;
   logic [7:0]  goto_target_ff, goto_target_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         press_time_ff   <= 10'd100;
         link_timeout_ff <= 16'd2000;
      end else if (csr_we) begin
         case (csr_index)
            REG_PRESS_TIME:   press_time_ff   <= csr_wdata[9:0];
            REG_LINK_TIMEOUT: link_timeout_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         command_word_ff <= '0;
         pending_ff      <= CMD_NONE;
         key_pressed_ff  <= 1'b0;
         press_timer_ff  <= '0;
         idle_timer_ff   <= '0;
         link_up_ff      <= 1'b0;
         last_pos_ff     <= '0;
         last_state_ff   <= '0;
         door_mode_ff    <= ST_UNKNOWN;
         position_ff     <= '0;
         goto_target_ff  <= '0;
      end else if (advance) begin
         command_word_ff <= command_word_in;
         pending_ff      <= pending_in;
         key_pressed_ff  <= key_pressed_in;
         press_timer_ff  <= press_timer_in;
         idle_timer_ff   <= idle_timer_in;
         link_up_ff      <= link_up_in;
         last_pos_ff     <= last_pos_in;
         last_state_ff   <= last_state_in;
         door_mode_ff    <= door_mode_in;
         position_ff     <= position_in;
         goto_target_ff  <= goto_target_in;
      end
   end

   always_comb begin
      logic [6:0]  n;
      logic [15:0] counter_w;
      logic [15:0] cmd_w;
      logic        moving;
      logic        reached;
      logic        q_en;
      logic [1:0]  q_code;
      logic        refused;
      logic [7:0]  tgt;

      command_word_in = command_word_ff;
      pending_in      = pending_ff;
      key_pressed_in  = key_pressed_ff;
      press_timer_in  = press_timer_ff;
      idle_timer_in   = idle_timer_ff;
      link_up_in      = link_up_ff;
      last_pos_in     = last_pos_ff;
      last_state_in   = last_state_ff;
      door_mode_in    = door_mode_ff;
      position_in     = position_ff;
      goto_target_in  = goto_target_ff;

      desc           = '0;
      desc.count     = CNT_W'(1);
      desc.data_flag = 1'b0;

      q_en    = 1'b0;
      q_code  = CMD_NONE;
      refused = 1'b0;
      reached = 1'b0;
      tgt     = '0;
      moving  = door_mode_ff inside {ST_CLOSING, ST_OPENING, ST_MOVEHALF, ST_MOVEVENT};

      n = (item.word_count > 7'(MAX_READ_WORDS)) ? 7'(MAX_READ_WORDS) : item.word_count;
      counter_w = {command_word_ff[15:8], 8'h00};
      cmd_w     = {command_word_ff[7:0], 8'h00};

      case (item.opcode)
         OP_TICK: begin
            if (idle_timer_ff < IDLE_MAX) idle_timer_in = idle_timer_ff + 17'd1;
            if (key_pressed_ff && press_timer_ff < PRESS_MAX)
               press_timer_in = press_timer_ff + 11'd1;
            if (link_up_ff && idle_timer_in > {1'b0, link_timeout_ff}) link_up_in = 1'b0;
         end
         OP_READ: begin
            idle_timer_in = '0;
            link_up_in    = 1'b1;
            if (n != 7'd0) begin
               desc.count     = n;
               desc.data_flag = 1'b1;
            end
            if (item.reg_address == ADDR_STATE) begin
               case (item.word_count)
                  7'd8: begin
                     desc.words[0] = counter_w;
                     desc.words[1] = cmd_w | 16'h0001;
                     if (pending_ff != CMD_NONE) begin
                        if (!key_pressed_ff) begin
                           // start the simulated key press
                           key_pressed_in = 1'b1;
                           press_timer_in = '0;
                           case (pending_ff)
                              CMD_OPEN:  desc.words[2] = PRESS_OPEN;
                              CMD_CLOSE: desc.words[2] = PRESS_CLOSE;
                              default:   desc.words[2] = PRESS_IMPULSE;
                           endcase
                        end else if (press_timer_ff > {1'b0, press_time_ff}) begin
                           key_pressed_in = 1'b0;
                           press_timer_in = '0;
                           pending_in     = CMD_NONE;
                           case (pending_ff)
                              CMD_OPEN:  desc.words[2] = RELEASE_OPEN;
                              CMD_CLOSE: desc.words[2] = RELEASE_CLOSE;
                              default:   desc.words[2] = RELEASE_IMPULSE;
                           endcase
                        end
                     end
                  end
                  7'd2: begin
                     desc.words[0] = counter_w | 16'h0004;
                     desc.words[1] = cmd_w;
                  end
                  7'd5: begin
                     desc.words[0] = counter_w;
                     desc.words[1] = cmd_w | 16'h0005;
                     desc.words[2] = INFO_WORD2;
                     desc.words[3] = INFO_WORD3;
                     desc.words[4] = INFO_WORD4;
                  end
                  default: ;
               endcase
            end
         end
         OP_WRITE: begin
            idle_timer_in = '0;
            link_up_in    = 1'b1;
            if (item.reg_address == ADDR_CMD) begin
               if (item.word_count != 7'd0) command_word_in = item.data_word0;
            end else if (item.reg_address == ADDR_BCAST) begin
               if (item.word_count > 7'd1) begin
                  last_pos_in = item.data_word1;
                  if (last_pos_ff[7:0] != item.data_word1[7:0]) begin
                     position_in = item.data_word1[7:0];
                     reached = (goto_target_ff != 8'd0) &&
                        ((door_mode_ff == ST_CLOSING && goto_target_ff >= position_in) ||
                         (door_mode_ff == ST_OPENING && goto_target_ff <= position_in));
                     if (reached) begin
                        // target passed: stop the door with an impulse
                        q_en           = moving;
                        q_code         = CMD_IMPULSE;
                        goto_target_in = '0;
                     end
                  end
               end
               if (item.word_count > 7'd2) begin
                  last_state_in = item.data_word2;
                  if (last_state_ff[15:8] != item.data_word2[15:8]) begin
                     case (item.data_word2[15:8])
                        BC_OPENING:  door_mode_in = ST_OPENING;
                        BC_CLOSING:  door_mode_in = ST_CLOSING;
                        BC_OPEN:     door_mode_in = ST_OPEN;
                        BC_CLOSED:   door_mode_in = ST_CLOSED;
                        BC_HALF:     door_mode_in = ST_HALF;
                        BC_MOVEVENT: door_mode_in = ST_MOVEVENT;
                        BC_MOVEHALF: door_mode_in = ST_MOVEHALF;
                        BC_VENT:     door_mode_in = ST_VENT;
                        BC_STOPPED:  door_mode_in = (item.data_word2[7:0] == BC_VENT_SUB) ?
                                                    ST_VENT : ST_STOPPED;
                        default: ;
                     endcase
                  end
               end
            end
         end
         default: begin
            case (item.request_kind)
               RQ_OPEN: begin
                  q_en   = 1'b1;
                  q_code = CMD_OPEN;
               end
               RQ_CLOSE: begin
                  q_en   = 1'b1;
                  q_code = CMD_CLOSE;
               end
               RQ_IMPULSE: begin
                  q_en   = 1'b1;
                  q_code = CMD_IMPULSE;
               end
               RQ_STOP: begin
                  q_en   = moving;
                  q_code = CMD_IMPULSE;
               end
               RQ_GOTO: begin
                  if (item.target_percent <= 7'd5) begin
                     q_en   = 1'b1;
                     q_code = CMD_CLOSE;
                  end else if (item.target_percent >= 7'd95) begin
                     q_en   = 1'b1;
                     q_code = CMD_OPEN;
                  end else begin
                     // target kept in half-percent units
                     tgt            = {item.target_percent, 1'b0};
                     goto_target_in = tgt;
                     if (position_ff < tgt) begin
                        q_en   = 1'b1;
                        q_code = CMD_OPEN;
                     end else if (position_ff > tgt) begin
                        q_en   = 1'b1;
                        q_code = CMD_CLOSE;
                     end
                  end
               end
               default: ;
            endcase
         end
      endcase

      // refuse to queue over a pending command
      if (q_en) begin
         if (pending_ff != CMD_NONE) refused = 1'b1;
         else pending_in = q_code;
      end

      desc.door_state    = door_mode_in;
      desc.door_position = position_in;
      desc.connected     = link_up_in;
      desc.refused       = refused;
   end

endmodule
`default_nettype wire

// ===== sv/dbs_emit.sv =====
// Result register that plays out a transaction's reply words one by one.
`default_nettype none
module dbs_emit
   import dbs_pkg::*;
#(
   parameter int unsigned MAX_READ_WORDS = DEFAULT_MAX_READ_WORDS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire desc_type    desc,
   input  wire logic        load,
   output      logic        free,
   output      logic        out_valid,
   input  wire logic        out_ready,
   output      logic [15:0] out_word,
   output      logic        out_flag,
   output      logic        out_last,
   output      logic [3:0]  out_state,
   output      logic [7:0]  out_position,
   output      logic        out_connected,
   output      logic        out_refused
);

   localparam int unsigned IDX_W = $clog2(MAX_READ_WORDS);

   desc_type         desc_ff;
   logic             valid_ff;
   logic [IDX_W-1:0] idx_ff;

   assign out_last = (CNT_W'(idx_ff) == desc_ff.count - CNT_W'(1));
   assign free     = !valid_ff || (out_ready && out_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (load) begin
         valid_ff <= 1'b1;
         idx_ff   <= '0;
      end else if (valid_ff && out_ready) begin
         if (out_last) valid_ff <= 1'b0;
         else idx_ff <= idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) desc_ff <= desc;
   end

   always_comb begin
      out_word = '0;
      if (idx_ff < IDX_W'(5)) begin
         case (idx_ff[2:0])
            3'd0:    out_word = desc_ff.words[0];
            3'd1:    out_word = desc_ff.words[1];
            3'd2:    out_word = desc_ff.words[2];
            3'd3:    out_word = desc_ff.words[3];
            3'd4:    out_word = desc_ff.words[4];
            default: out_word = '0;
         endcase
      end
   end

   assign out_valid     = valid_ff;
   assign out_flag      = desc_ff.data_flag;
   assign out_state     = desc_ff.door_state;
   assign out_position  = desc_ff.door_position;
   assign out_connected = desc_ff.connected;
   assign out_refused   = desc_ff.refused;

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the door bus slave command bridge: directed table, then random.
`timescale 1ns / 1ps
module tb_top;
   import dbs_pkg::*;

   localparam int READ_LIMIT      = 64;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int HOLD_CYCLES     = 400;
   localparam int HOLD_AFTER      = 150;
   localparam int ITEMS_PER_PHASE = 18;
   localparam int SENDER          = 0;
   localparam int RECEIVER        = 1;

   typedef struct packed {
      logic [15:0] word;
      logic        valid;
      logic        last;
      logic [3:0]  state;
      logic [7:0]  pos;
      logic        conn;
      logic        refused;
   } reply_t;

   typedef struct {
      bit           is_cfg;
      logic         cfg_index;
      logic [15:0]  cfg_value;
      req_item_type item;
      bit           typed;
      reply_t       reply;
   } stim_row_t;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [87:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we;
   logic        csr_index;
   logic [15:0] csr_wdata;

   // Bridge state as the predictor sees it
   logic [9:0]  press_limit;
   logic [15:0] link_limit;
   logic [15:0] cmd_word;
   logic [1:0]  cmd_pending;
   bit          key_down;
   logic [10:0] press_ticks;
   logic [16:0] idle_ticks;
   bit          link_ok;
   logic [15:0] pos_word;
   logic [15:0] state_word;
   logic [3:0]  door_mode;
   logic [7:0]  pos_byte;
   logic [7:0]  goto_pos;
   bit          refused_now;

   reply_t    replies_due[$];
   stim_row_t directed_rows[$];
   int        mismatches;
   int        results_seen;
   int        stalled_cycles;
   int        gap_left[2];
   bit        gap_calm[2];

   door_bus_slave_command_bridge #(.MAX_READ_WORDS(READ_LIMIT)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic void queue_reply(reply_t r);
      replies_due.insert(replies_due.size(), r);
   endfunction

   function automatic void add_row(stim_row_t r);
      directed_rows.insert(directed_rows.size(), r);
   endfunction

   function automatic bit door_moving();
      return door_mode == ST_CLOSING || door_mode == ST_OPENING ||
             door_mode == ST_MOVEHALF || door_mode == ST_MOVEVENT;
   endfunction

   // Queue a command unless one is still pending; a clash flags the refusal.
   function automatic void queue_cmd(bit cond, logic [1:0] code);
      if (cond) begin
         if (cmd_pending != CMD_NONE) refused_now = 1;
         else cmd_pending = code;
      end
   endfunction

   function automatic logic [15:0] key_word(logic [1:0] code, bit press);
      case (code)
         CMD_OPEN:    return press ? PRESS_OPEN : RELEASE_OPEN;
         CMD_CLOSE:   return press ? PRESS_CLOSE : RELEASE_CLOSE;
         CMD_IMPULSE: return press ? PRESS_IMPULSE : RELEASE_IMPULSE;
         default:     return 16'h0000;
      endcase
   endfunction

   function automatic reply_t status_reply(logic [15:0] word, logic valid, logic last);
      reply_t r;
      r.word    = word;
      r.valid   = valid;
      r.last    = last;
      r.state   = door_mode;
      r.pos     = pos_byte;
      r.conn    = link_ok;
      r.refused = refused_now;
      return r;
   endfunction

   function automatic reply_t quiet_reply(logic [3:0] state, logic [7:0] pos, logic conn,
                                          logic refused);
      reply_t r;
      r.word    = 16'h0000;
      r.valid   = 1'b0;
      r.last    = 1'b1;
      r.state   = state;
      r.pos     = pos;
      r.conn    = conn;
      r.refused = refused;
      return r;
   endfunction

   // Apply one bus event to the bridge state and queue the replies it produces.
   task automatic run_bridge_event(input req_item_type it);
      logic [15:0] words [READ_LIMIT];
      logic [6:0]  n;
      logic [15:0] counter;
      logic [15:0] cmd_hi;
      refused_now = 0;
      n = 0;
      case (it.opcode)
         OP_TICK: begin
            if (idle_ticks < IDLE_MAX) idle_ticks++;
            if (key_down && press_ticks < PRESS_MAX) press_ticks++;
            if (link_ok && idle_ticks > link_limit) link_ok = 0;
         end
         OP_READ: begin
            idle_ticks = 0;
            link_ok    = 1;
            counter    = cmd_word & 16'hFF00;
            cmd_hi     = {cmd_word[7:0], 8'h00};
            n = (it.word_count > READ_LIMIT) ? 7'(READ_LIMIT) : it.word_count;
            foreach (words[i]) words[i] = 16'h0000;
            if (it.reg_address == ADDR_STATE && n == 8) begin
               words[0] = counter;
               words[1] = cmd_hi | 16'h0001;
               // press on the first poll, release once the key has been held long enough
               if (cmd_pending != CMD_NONE) begin
                  if (!key_down) begin
                     words[2]    = key_word(cmd_pending, 1);
                     key_down    = 1;
                     press_ticks = 0;
                  end else if (press_ticks > press_limit) begin
                     words[2]    = key_word(cmd_pending, 0);
                     key_down    = 0;
                     press_ticks = 0;
                     cmd_pending = CMD_NONE;
                  end
               end
            end else if (it.reg_address == ADDR_STATE && n == 2) begin
               words[0] = counter | 16'h0004;
               words[1] = cmd_hi;
            end else if (it.reg_address == ADDR_STATE && n == 5) begin
               words[0] = counter;
               words[1] = cmd_hi | 16'h0005;
               words[2] = INFO_WORD2;
               words[3] = INFO_WORD3;
               words[4] = INFO_WORD4;
            end
         end
         OP_WRITE: begin
            idle_ticks = 0;
            link_ok    = 1;
            if (it.reg_address == ADDR_CMD) begin
               if (it.word_count >= 1) cmd_word = it.data_word0;
            end else if (it.reg_address == ADDR_BCAST) begin
               if (it.word_count > 1) begin
                  if (pos_word[7:0] != it.data_word1[7:0]) begin
                     pos_byte = it.data_word1[7:0];
                     if (goto_pos != 0 &&
                         ((door_mode == ST_CLOSING && goto_pos >= pos_byte) ||
                          (door_mode == ST_OPENING && goto_pos <= pos_byte))) begin
                        queue_cmd(door_moving(), CMD_IMPULSE);
                        goto_pos = 0;
                     end
                  end
                  pos_word = it.data_word1;
               end
               if (it.word_count > 2) begin
                  if (state_word[15:8] != it.data_word2[15:8]) begin
                     case (it.data_word2[15:8])
                        BC_OPENING:  door_mode = ST_OPENING;
                        BC_CLOSING:  door_mode = ST_CLOSING;
                        BC_OPEN:     door_mode = ST_OPEN;
                        BC_CLOSED:   door_mode = ST_CLOSED;
                        BC_HALF:     door_mode = ST_HALF;
                        BC_MOVEVENT: door_mode = ST_MOVEVENT;
                        BC_MOVEHALF: door_mode = ST_MOVEHALF;
                        BC_VENT:     door_mode = ST_VENT;
                        BC_STOPPED:  door_mode = (it.data_word2[7:0] == BC_VENT_SUB) ?
                                                 ST_VENT : ST_STOPPED;
                        default: ;
                     endcase
                  end
                  state_word = it.data_word2;
               end
            end
         end
         default: begin
            case (it.request_kind)
               RQ_OPEN:    queue_cmd(1, CMD_OPEN);
               RQ_CLOSE:   queue_cmd(1, CMD_CLOSE);
               RQ_IMPULSE: queue_cmd(1, CMD_IMPULSE);
               RQ_STOP:    queue_cmd(door_moving(), CMD_IMPULSE);
               RQ_GOTO: begin
                  if (it.target_percent <= 5) begin
                     queue_cmd(1, CMD_CLOSE);
                  end else if (it.target_percent >= 95) begin
                     queue_cmd(1, CMD_OPEN);
                  end else begin
                     goto_pos = {it.target_percent, 1'b0};
                     queue_cmd(pos_byte < goto_pos, CMD_OPEN);
                     queue_cmd(pos_byte > goto_pos, CMD_CLOSE);
                  end
               end
               default: ;
            endcase
         end
      endcase
      if (n > 0) begin
         for (int i = 0; i < n; i++)
            queue_reply(status_reply(words[i], 1'b1, i == n - 1));
      end else begin
         queue_reply(status_reply(16'h0000, 1'b0, 1'b1));
      end
   endtask

   // Run without gaps for a stretch, or idle at random; both sides switch between the two modes.
   function automatic int draw_gap(int side);
      if (gap_left[side] == 0) begin
         gap_left[side] = $urandom_range(8, 30);
         gap_calm[side] = ($urandom_range(0, 2) == 0);
      end
      gap_left[side]--;
      return gap_calm[side] ? 0 : $urandom_range(0, 17);
   endfunction

   function automatic req_item_type random_event();
      req_item_type it;
      int           pick;
      logic [7:0]   code;
      it = '0;
      it.reg_address    = 16'($urandom);
      it.word_count     = 7'($urandom_range(0, 64));
      it.data_word0     = 16'($urandom);
      it.data_word1     = 16'($urandom);
      it.data_word2     = 16'($urandom);
      it.request_kind   = 3'($urandom_range(0, 7));
      it.target_percent = 7'($urandom_range(0, 100));
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         it.opcode = OP_TICK;
      end else if (pick < 60) begin
         it.opcode = OP_READ;
         if ($urandom_range(0, 9) < 7) begin
            it.reg_address = ADDR_STATE;
            case ($urandom_range(0, 4))
               0:       it.word_count = 2;
               1:       it.word_count = 5;
               default: it.word_count = 8;
            endcase
         end else begin
            if ($urandom_range(0, 1) == 0) it.reg_address = ADDR_STATE;
            if ($urandom_range(0, 3) != 0) it.word_count = 7'($urandom_range(0, 9));
         end
      end else if (pick < 82) begin
         it.opcode = OP_WRITE;
         pick = $urandom_range(0, 19);
         if (pick < 7) begin
            it.reg_address = ADDR_CMD;
            it.word_count  = 7'($urandom_range(0, 3));
         end else if (pick < 18) begin
            it.reg_address = ADDR_BCAST;
            it.word_count  = 7'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : 3);
            it.data_word1[7:0] = ($urandom_range(0, 3) == 0) ? pos_word[7:0] :
                                 8'($urandom_range(0, 200));
            case ($urandom_range(0, 10))
               0:       code = BC_STOPPED;
               1:       code = BC_OPENING;
               2:       code = BC_CLOSING;
               3:       code = BC_MOVEHALF;
               4:       code = BC_MOVEVENT;
               5:       code = BC_VENT;
               6:       code = BC_OPEN;
               7:       code = BC_CLOSED;
               8:       code = BC_HALF;
               9:       code = BC_OPENING;
               default: code = 8'($urandom);
            endcase
            it.data_word2[15:8] = code;
            if ($urandom_range(0, 3) == 0) it.data_word2[7:0] = BC_VENT_SUB;
         end
      end else begin
         it.opcode       = OP_USER;
         it.request_kind = 3'(($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) :
                              $urandom_range(0, 4));
      end
      return it;
   endfunction

   function automatic stim_row_t ev_row(op_type op, logic [15:0] addr, logic [6:0] cnt,
                                        logic [15:0] d0, logic [15:0] d1, logic [15:0] d2,
                                        logic [2:0] kind, logic [6:0] pct);
      stim_row_t r;
      r.is_cfg              = 0;
      r.cfg_index           = REG_PRESS_TIME;
      r.cfg_value           = 16'h0000;
      r.item.opcode         = op;
      r.item.reg_address    = addr;
      r.item.word_count     = cnt;
      r.item.data_word0     = d0;
      r.item.data_word1     = d1;
      r.item.data_word2     = d2;
      r.item.request_kind   = kind;
      r.item.target_percent = pct;
      r.typed               = 0;
      r.reply               = '0;
      return r;
   endfunction

   function automatic stim_row_t cfg_row(logic idx, logic [15:0] val);
      stim_row_t r;
      r           = ev_row(OP_TICK, 16'h0000, 7'd0, 16'h0, 16'h0, 16'h0, RQ_OPEN, 7'd0);
      r.is_cfg    = 1;
      r.cfg_index = idx;
      r.cfg_value = val;
      return r;
   endfunction

   function automatic stim_row_t with_reply(stim_row_t r, reply_t rp);
      r.typed = 1;
      r.reply = rp;
      return r;
   endfunction

   // Present one transaction; the predictor runs as it goes out, in acceptance order.
   task automatic offer(input req_item_type it, input bit typed, input reply_t typed_reply);
      int gap;
      gap = draw_gap(SENDER);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(negedge clock);
      end
      run_bridge_event(it);
      if (typed) replies_due[replies_due.size() - 1] = typed_reply;
      req_tdata  <= {7'b0, it.target_percent, it.request_kind, it.data_word2, it.data_word1,
                     it.data_word0, it.word_count, it.reg_address};
      req_tuser  <= it.opcode;
      req_tvalid <= 1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // Write a register once the bridge has drained.
   task automatic write_reg(input logic idx, input logic [15:0] val);
      req_tvalid <= 0;
      while (replies_due.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_we    <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 0;
      @(negedge clock);
      if (idx == REG_PRESS_TIME) press_limit = val[9:0];
      else link_limit = val;
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : reply_monitor
      reply_t got;
      reply_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.word    = rsp_tdata[15:0];
         got.state   = rsp_tdata[19:16];
         got.pos     = rsp_tdata[27:20];
         got.conn    = rsp_tdata[28];
         got.refused = rsp_tdata[29];
         got.valid   = rsp_tuser;
         got.last    = rsp_tlast;
         results_seen++;
         if (replies_due.size() == 0) begin
            $error("reply_word: expected no transaction, got %0h", got.word);
            mismatches++;
         end else begin
            want = replies_due.pop_front();
            check_field("reply_word", want.word, got.word);
            check_field("word_valid", 16'(want.valid), 16'(got.valid));
            check_field("last_word", 16'(want.last), 16'(got.last));
            check_field("door_state", 16'(want.state), 16'(got.state));
            check_field("door_position", 16'(want.pos), 16'(got.pos));
            check_field("connected", 16'(want.conn), 16'(got.conn));
            check_field("request_refused", 16'(want.refused), 16'(got.refused));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles == WATCHDOG_LIMIT) begin
         $display("** door_bus_slave_command_bridge: FAILED **");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   initial begin : receiver
      int gap;
      bit held;
      rsp_tready = 0;
      held       = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = draw_gap(RECEIVER);
         // one long hold-off so the bridge backs up into its input
         if (!held && results_seen >= HOLD_AFTER) begin
            held = 1;
            gap  = HOLD_CYCLES;
         end
         if (gap > 0) begin
            rsp_tready <= 0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   initial begin : stimulus
      clock          = 0;
      reset          = 1;
      req_tvalid     = 0;
      req_tdata      = '0;
      req_tuser      = '0;
      csr_we         = 0;
      csr_index      = REG_PRESS_TIME;
      csr_wdata      = '0;
      mismatches     = 0;
      results_seen   = 0;
      stalled_cycles = 0;
      gap_left       = '{0, 0};
      gap_calm       = '{0, 0};
      press_limit    = 10'd100;
      link_limit     = 16'd2000;
      cmd_word       = '0;
      cmd_pending    = CMD_NONE;
      key_down       = 0;
      press_ticks    = '0;
      idle_ticks     = '0;
      link_ok        = 0;
      pos_word       = '0;
      state_word     = '0;
      door_mode      = ST_UNKNOWN;
      pos_byte       = '0;
      goto_pos       = '0;
      refused_now    = 0;

      add_row(with_reply(
         ev_row(OP_TICK, 16'h0000, 7'd0, 16'h0, 16'h0, 16'h0, RQ_OPEN, 7'd0),
         quiet_reply(ST_UNKNOWN, 8'd0, 1'b0, 1'b0)));
      add_row(with_reply(
         ev_row(OP_READ, ADDR_STATE, 7'd0, 16'h0, 16'h0, 16'h0, RQ_OPEN, 7'd0),
         quiet_reply(ST_UNKNOWN, 8'd0, 1'b1, 1'b0)));
      add_row(with_reply(
         ev_row(OP_WRITE, ADDR_CMD, 7'd1, 16'hFFFF, 16'h0, 16'h0, RQ_OPEN, 7'd0),
         quiet_reply(ST_UNKNOWN, 8'd0, 1'b1, 1'b0)));
      add_row(ev_row(OP_READ, ADDR_STATE, 7'd2, 0, 0, 0, RQ_OPEN, 7'd0));
      add_row(ev_row(OP_READ, ADDR_STATE, 7'd5, 0, 0, 0, RQ_OPEN, 7'd0));
      add_row(ev_row(OP_READ, ADDR_STATE, 7'd8, 0, 0, 0, RQ_OPEN, 7'd0));
      add_row(ev_row(OP_WRITE, ADDR_CMD, 7'd0, 16'h1234, 0, 0, RQ_OPEN, 7'd0));
      add_row(ev_row(OP_READ, 16'h0000, 7'd3, 0, 0, 0, RQ_OPEN, 7'd0));
      // count beyond the reply limit gets cut
      add_row(ev_row(OP_READ, ADDR_STATE, 7'd127, 0, 0, 0, RQ_OPEN, 7'd0));
      add_row(ev_row(OP_WRITE, 16'hFFFF, 7'd64, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                     3'd7, 7'd100));
      add_row(ev_row(OP_WRITE, ADDR_BCAST, 7'd3, 16'h0, 16'h00C8,
                     {BC_CLOSING, 8'h00}, RQ_OPEN, 7'd0));
      add_row(ev_row(OP_USER, 16'h0, 7'd0, 0, 0, 0, RQ_GOTO, 7'd50));
      add_row(with_reply(
         ev_row(OP_USER, 16'h0, 7'd0, 16'h0, 16'h0, 16'h0, RQ_OPEN, 7'd0),
         quiet_reply(ST_CLOSING, 8'd200, 1'b1, 1'b1)));
      add_row(ev_row(OP_READ, ADDR_STATE, 7'd8, 0, 0, 0, RQ_OPEN, 7'd0));
      add_row(ev_row(OP_READ, ADDR_STATE, 7'd8, 0, 0, 0, RQ_OPEN, 7'd0));
      add_row(cfg_row(REG_PRESS_TIME, 16'd1));
      add_row(cfg_row(REG_LINK_TIMEOUT, 16'd2));
      repeat (3)
         add_row(ev_row(OP_TICK, 16'h0, 7'd0, 0, 0, 0, RQ_OPEN, 7'd0));
      add_row(ev_row(OP_READ, ADDR_STATE, 7'd8, 0, 0, 0, RQ_OPEN, 7'd0));
      // position passes the goto target while closing
      add_row(ev_row(OP_WRITE, ADDR_BCAST, 7'd3, 16'h0, 16'h0050,
                     {BC_CLOSING, 8'h00}, RQ_OPEN, 7'd0));
      add_row(ev_row(OP_USER, 16'h0, 7'd0, 0, 0, 0, RQ_STOP, 7'd0));
      add_row(ev_row(OP_WRITE, ADDR_BCAST, 7'd3, 16'h0, 16'h0050,
                     {BC_STOPPED, BC_VENT_SUB}, RQ_OPEN, 7'd0));
      add_row(ev_row(OP_WRITE, ADDR_BCAST, 7'd2, 16'h0, 16'hFF32, 16'h3300,
                     RQ_OPEN, 7'd0));
      add_row(ev_row(OP_WRITE, ADDR_BCAST, 7'd3, 16'h0, 16'hFF32, 16'h3300,
                     RQ_OPEN, 7'd0));
      add_row(ev_row(OP_USER, 16'h0, 7'd0, 0, 0, 0, 3'd7, 7'd0));
      add_row(ev_row(OP_USER, 16'h0, 7'd0, 0, 0, 0, RQ_GOTO, 7'd0));
      // goto onto the current position queues nothing
      add_row(ev_row(OP_USER, 16'h0, 7'd0, 0, 0, 0, RQ_GOTO, 7'd25));

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_cfg)
            write_reg(directed_rows[i].cfg_index, directed_rows[i].cfg_value);
         else
            offer(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].reply);
      end

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            1: begin
               write_reg(REG_PRESS_TIME, 16'd1023);
               write_reg(REG_LINK_TIMEOUT, 16'hFFFF);
            end
            2: begin
               write_reg(REG_PRESS_TIME, 16'd1);
               write_reg(REG_LINK_TIMEOUT, 16'd1);
            end
            3: begin
               write_reg(REG_PRESS_TIME, 16'd9);
               write_reg(REG_LINK_TIMEOUT, 16'd40);
            end
            default: ;
         endcase
         repeat (ITEMS_PER_PHASE) offer(random_event(), 1'b0, '0);
      end

      req_tvalid <= 0;
      while (replies_due.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (mismatches == 0)
         $display("** door_bus_slave_command_bridge: PASSED **");
      else
         $display("** door_bus_slave_command_bridge: FAILED **");
      $finish;
   end

endmodule
